// File: rtl/core/cpfa_pkg.sv
package cpfa_pkg;

  localparam int FRAME_COUNT = 1024;
  localparam int OWNER_BITS  = 4;
  localparam int FRAME_BITS  = $clog2(FRAME_COUNT);

  localparam int PAGE_SHIFT  = 12;
  localparam int BYTE_W      = 32;
  localparam int OWNER_W     = 4;
  localparam int CFG_W       = 11;
  localparam int ADDR_W      = 22;
  localparam int IDX_W       = BYTE_W - PAGE_SHIFT;
  localparam int PAGE_CNT_W  = IDX_W + 1;
  // scan index must hold the boundary register as well as the table size
  localparam int SCAN_W      = (FRAME_BITS + 1 > CFG_W) ? FRAME_BITS + 1 : CFG_W;
  localparam int ENTRY_W     = OWNER_BITS + FRAME_BITS;

  localparam logic [PAGE_CNT_W-1:0] PAGE_ROUND = PAGE_CNT_W'((1 << PAGE_SHIFT) - 1);

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic {
    STATUS_OK  = 1'b0,
    STATUS_ERR = 1'b1
  } status_t;

  typedef struct packed {
    logic                func;
    logic [BYTE_W-1:0]   byte_count;
    logic [BYTE_W-1:0]   block_address;
    logic [OWNER_W-1:0]  owner_id;
  } in_word_t;

  typedef struct packed {
    logic                status;
    logic [ADDR_W-1:0]   result_address;
  } out_word_t;

  typedef struct packed {
    logic [OWNER_BITS-1:0] owner;
    logic [FRAME_BITS-1:0] block_start;
  } frame_entry_t;

endpackage

// File: rtl/core/cpfa_ram.sv
module cpfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/contiguous_page_frame_allocator_core.sv
// A zero owner, or a free index past the table or below the boundary, goes straight to the result.
// Allocate scans frames for a free run, then marks its pages; a failed scan reports an error.
// Free clears frames of the block until a miss or the last frame; a miss on the first is an error.
// Throughput: one request at a time, set by the one-entry-per-cycle walk over the
// single frame table RAM.
// Reset (rst_n low, synchronous): a clearing pass writes every frame free; no request
// is taken until it ends. Config writes are taken whenever rst_n is high.
module contiguous_page_frame_allocator_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [cpfa_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  cpfa_pkg::in_word_t           in_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output cpfa_pkg::out_word_t          out_word
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_RESULT
  } state_t;

  localparam int FB = cpfa_pkg::FRAME_BITS;
  localparam int SW = cpfa_pkg::SCAN_W;

  state_t                              state_r, state_nxt;
  logic [cpfa_pkg::CFG_W-1:0]          ff_r;
  logic [FB-1:0]                       clr_idx_r, clr_idx_nxt;
  logic                                func_r, func_nxt;
  logic [cpfa_pkg::OWNER_BITS-1:0]     own_r, own_nxt;
  logic [cpfa_pkg::PAGE_CNT_W-1:0]     pages_r, pages_nxt;
  logic [FB-1:0]                       orig_r, orig_nxt;
  logic [SW-1:0]                       rd_idx_r, rd_idx_nxt;
  logic                                vld_r, vld_nxt;
  logic [FB-1:0]                       chk_idx_r, chk_idx_nxt;
  logic [FB:0]                         run_r, run_nxt;
  logic [FB-1:0]                       mk_idx_r, mk_idx_nxt;
  logic [FB-1:0]                       start_r, start_nxt;
  logic [FB-1:0]                       end_r, end_nxt;
  logic                                res_status_r, res_status_nxt;
  logic [cpfa_pkg::ADDR_W-1:0]         res_addr_r, res_addr_nxt;
  logic                                out_valid_r, out_valid_nxt;
  cpfa_pkg::out_word_t                 out_word_r, out_word_nxt;

  logic                                mem_we, mem_re;
  logic [FB-1:0]                       mem_waddr;
  cpfa_pkg::frame_entry_t              mem_wdata, mem_rdata;

  logic                                in_acc;
  logic [cpfa_pkg::IDX_W-1:0]          free_idx;
  logic [cpfa_pkg::BYTE_W:0]           in_round;
  logic [cpfa_pkg::PAGE_CNT_W-1:0]     in_pages;
  logic                                rd_more;
  logic [FB:0]                         run_inc;
  logic                                free_hit;

  cpfa_ram #(
    .WIDTH (cpfa_pkg::ENTRY_W),
    .DEPTH (cpfa_pkg::FRAME_COUNT)
  ) u_frame_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_idx_r[FB-1:0]),
    .rdata (mem_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign free_idx = in_word.block_address[cpfa_pkg::BYTE_W-1:cpfa_pkg::PAGE_SHIFT];
  // round up in full width so large byte counts keep their page count
  assign in_round = {1'b0, in_word.byte_count} +
                    (cpfa_pkg::BYTE_W+1)'(cpfa_pkg::PAGE_ROUND);
  assign in_pages = in_round[cpfa_pkg::BYTE_W:cpfa_pkg::PAGE_SHIFT];
  assign rd_more  = rd_idx_r < SW'(cpfa_pkg::FRAME_COUNT);
  assign run_inc  = run_r + (FB+1)'(1);
  assign free_hit = (mem_rdata.owner == own_r) && (mem_rdata.block_start == orig_r);
  assign mem_re   = (state_r == ST_SCAN) && rd_more;

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    func_nxt       = func_r;
    own_nxt        = own_r;
    pages_nxt      = pages_r;
    orig_nxt       = orig_r;
    rd_idx_nxt     = rd_idx_r;
    vld_nxt        = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    run_nxt        = run_r;
    mk_idx_nxt     = mk_idx_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;
    mem_we         = 1'b0;
    mem_waddr      = clr_idx_r;
    mem_wdata      = '0;

    case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        clr_idx_nxt = clr_idx_r + FB'(1);
        if (clr_idx_r == FB'(cpfa_pkg::FRAME_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          func_nxt       = in_word.func;
          own_nxt        = cpfa_pkg::OWNER_BITS'(in_word.owner_id);
          pages_nxt      = in_pages;
          orig_nxt       = free_idx[FB-1:0];
          run_nxt        = '0;
          res_status_nxt = cpfa_pkg::STATUS_ERR;
          res_addr_nxt   = '0;
          if (in_word.owner_id == '0) begin
            state_nxt = ST_RESULT;
          end else if (in_word.func == cpfa_pkg::FUNC_ALLOC) begin
            rd_idx_nxt = SW'(ff_r);
            state_nxt  = ST_SCAN;
          end else if (free_idx >= cpfa_pkg::IDX_W'(cpfa_pkg::FRAME_COUNT) ||
                       free_idx < cpfa_pkg::IDX_W'(ff_r)) begin
            state_nxt = ST_RESULT;
          end else begin
            rd_idx_nxt = SW'(free_idx);
            state_nxt  = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // reads stream one per cycle; data for chk_idx_r arrives with vld_r
        if (rd_more) begin
          vld_nxt     = 1'b1;
          chk_idx_nxt = rd_idx_r[FB-1:0];
          rd_idx_nxt  = rd_idx_r + SW'(1);
        end
        if (vld_r) begin
          if (func_r == cpfa_pkg::FUNC_ALLOC) begin
            if (mem_rdata.owner != '0) begin
              run_nxt = '0;
            end else if (pages_r == '0) begin
              res_status_nxt = cpfa_pkg::STATUS_OK;
              res_addr_nxt   = cpfa_pkg::ADDR_W'({chk_idx_r, {cpfa_pkg::PAGE_SHIFT{1'b0}}});
              vld_nxt        = 1'b0;
              state_nxt      = ST_RESULT;
            end else if (cpfa_pkg::PAGE_CNT_W'(run_inc) >= pages_r) begin
              // pages <= run+1 <= FRAME_COUNT here, so the low bits suffice
              start_nxt  = FB'(({1'b0, chk_idx_r} + (FB+1)'(1)) - pages_r[FB:0]);
              mk_idx_nxt = FB'(({1'b0, chk_idx_r} + (FB+1)'(1)) - pages_r[FB:0]);
              end_nxt    = chk_idx_r;
              vld_nxt    = 1'b0;
              state_nxt  = ST_MARK;
            end else begin
              run_nxt = run_inc;
            end
          end else begin
            if (free_hit) begin
              mem_we    = 1'b1;
              mem_waddr = chk_idx_r;
              mem_wdata = '{owner: '0, block_start: mem_rdata.block_start};
              if (chk_idx_r == FB'(cpfa_pkg::FRAME_COUNT - 1)) begin
                res_status_nxt = cpfa_pkg::STATUS_OK;
                vld_nxt        = 1'b0;
                state_nxt      = ST_RESULT;
              end
            end else begin
              // a miss on the first frame is an error, later it ends the block
              res_status_nxt = (chk_idx_r == orig_r) ? cpfa_pkg::STATUS_ERR
                                                     : cpfa_pkg::STATUS_OK;
              vld_nxt        = 1'b0;
              state_nxt      = ST_RESULT;
            end
          end
        end else if (!rd_more) begin
          // table exhausted with nothing in flight
          res_status_nxt = (func_r == cpfa_pkg::FUNC_ALLOC) ? cpfa_pkg::STATUS_ERR
                                                            : cpfa_pkg::STATUS_OK;
          state_nxt      = ST_RESULT;
        end
      end

      ST_MARK: begin
        mem_we     = 1'b1;
        mem_waddr  = mk_idx_r;
        mem_wdata  = '{owner: own_r, block_start: start_r};
        mk_idx_nxt = mk_idx_r + FB'(1);
        if (mk_idx_r == end_r) begin
          res_status_nxt = cpfa_pkg::STATUS_OK;
          res_addr_nxt   = cpfa_pkg::ADDR_W'({start_r, {cpfa_pkg::PAGE_SHIFT{1'b0}}});
          state_nxt      = ST_RESULT;
        end
      end

      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{status: res_status_r, result_address: res_addr_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      ff_r        <= '0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        ff_r <= cfg_wdata;
      end
    end
    func_r       <= func_nxt;
    own_r        <= own_nxt;
    pages_r      <= pages_nxt;
    orig_r       <= orig_nxt;
    rd_idx_r     <= rd_idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    run_r        <= run_nxt;
    mk_idx_r     <= mk_idx_nxt;
    start_r      <= start_nxt;
    end_r        <= end_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_word_r   <= out_word_nxt;
  end

  a_no_reserved_write: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != ST_CLEAR) |-> (cpfa_pkg::CFG_W'(mem_waddr) >= ff_r))
    else $error("write to reserved frame");

  a_mark_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == ST_MARK) |-> (mem_wdata.owner != '0))
    else $error("allocate marks frame with zero owner");

  a_free_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == ST_SCAN) |-> (mem_wdata.owner == '0 && func_r == cpfa_pkg::FUNC_FREE))
    else $error("scan write outside free");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("accepted word not processed");

endmodule
